// ----- hw/rtl/sip_pkg.sv -----
`default_nettype none

package sip_pkg;

    // Default geometry settings
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed field widths
    localparam int IN_FIELD_W  = 16;
    localparam int IN_FIELDS   = 8;
    localparam int IN_DATA_W   = IN_FIELD_W * IN_FIELDS;
    localparam int OUT_COORD_W = 32;
    localparam int OUT_DATA_W  = 2 * OUT_COORD_W;
    localparam int OUT_USER_W  = 8;

    // Per-item control that rides alongside the arithmetic
    typedef struct packed {
        logic hit;
        logic den_zero;
        logic neg_x;
        logic neg_y;
    } sip_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sip_front.sv -----
`default_nettype none

// Differences, cross terms, side tests and scaled dividends: six stages.
module sip_front
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MW         = 2 * (COORD_BITS + 1) + 1,
    parameter int NW         = MW + COORD_BITS + 1 + FRAC_BITS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [IN_DATA_W-1:0]   in_data,
    output logic                        out_valid,
    output sip_ctl_t                    out_ctl,
    output logic [MW-1:0]               out_den,
    output logic [NW-1:0]               out_dvd_x,
    output logic [NW-1:0]               out_dvd_y,
    output logic [OUT_COORD_W-1:0]      out_start_x,
    output logic [OUT_COORD_W-1:0]      out_start_y
);

    localparam int CW  = COORD_BITS;
    localparam int DFW = CW + 1;
    localparam int PW  = 2 * DFW;
    localparam int XW  = PW + 1;
    localparam int NPW = MW + DFW;
    localparam int H   = MW / 2;
    localparam int HW  = MW - H;

    logic [5:0] v_reg;

    // Sign-extend the low COORD_BITS of one field
    function automatic logic signed [DFW-1:0] ext(input logic [IN_FIELD_W-1:0] f);
        logic [CW-1:0] t;
        t = CW'(f);
        return {t[CW-1], t};
    endfunction

    function automatic logic [OUT_COORD_W-1:0] start_of(input logic [DFW-1:0] a);
        logic [OUT_COORD_W-1:0] w;
        w = {{(OUT_COORD_W-DFW){a[DFW-1]}}, a};
        return w << FRAC_BITS;
    endfunction

    logic signed [DFW-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
    assign x1 = ext(in_data[0*IN_FIELD_W +: IN_FIELD_W]);
    assign y1 = ext(in_data[1*IN_FIELD_W +: IN_FIELD_W]);
    assign x2 = ext(in_data[2*IN_FIELD_W +: IN_FIELD_W]);
    assign y2 = ext(in_data[3*IN_FIELD_W +: IN_FIELD_W]);
    assign x3 = ext(in_data[4*IN_FIELD_W +: IN_FIELD_W]);
    assign y3 = ext(in_data[5*IN_FIELD_W +: IN_FIELD_W]);
    assign x4 = ext(in_data[6*IN_FIELD_W +: IN_FIELD_W]);
    assign y4 = ext(in_data[7*IN_FIELD_W +: IN_FIELD_W]);

    // Stage 1: coordinate differences
    logic signed [DFW-1:0] d12x_reg, d12y_reg, d13x_reg, d13y_reg, d14x_reg, d14y_reg;
    logic signed [DFW-1:0] d23x_reg, d23y_reg, d34x_reg, d34y_reg;
    logic [OUT_COORD_W-1:0] s1_sx_reg, s1_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d12x_reg  <= x1 - x2;
            d12y_reg  <= y1 - y2;
            d13x_reg  <= x1 - x3;
            d13y_reg  <= y1 - y3;
            d14x_reg  <= x1 - x4;
            d14y_reg  <= y1 - y4;
            d23x_reg  <= x2 - x3;
            d23y_reg  <= y2 - y3;
            d34x_reg  <= x3 - x4;
            d34y_reg  <= y3 - y4;
            s1_sx_reg <= start_of(x1);
            s1_sy_reg <= start_of(y1);
        end
    end

    // Stage 2: the twelve cross-term products
    logic signed [PW-1:0] p1a_reg, p1b_reg, p2a_reg, p2b_reg, p3a_reg, p3b_reg;
    logic signed [PW-1:0] p4a_reg, p4b_reg, pda_reg, pdb_reg, pna_reg, pnb_reg;
    logic signed [DFW-1:0] s2_dx_reg, s2_dy_reg;
    logic [OUT_COORD_W-1:0] s2_sx_reg, s2_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1a_reg   <= d13x_reg * d12y_reg;
            p1b_reg   <= d13y_reg * d12x_reg;
            p2a_reg   <= d14x_reg * d12y_reg;
            p2b_reg   <= d14y_reg * d12x_reg;
            p3a_reg   <= d13y_reg * d34x_reg;
            p3b_reg   <= d13x_reg * d34y_reg;
            p4a_reg   <= d23y_reg * d34x_reg;
            p4b_reg   <= d23x_reg * d34y_reg;
            pda_reg   <= d12x_reg * d34y_reg;
            pdb_reg   <= d34x_reg * d12y_reg;
            pna_reg   <= d34y_reg * d13x_reg;
            pnb_reg   <= d34x_reg * d13y_reg;
            s2_dx_reg <= d12x_reg;
            s2_dy_reg <= d12y_reg;
            s2_sx_reg <= s1_sx_reg;
            s2_sy_reg <= s1_sy_reg;
        end
    end

    // Stage 3: cross terms, denominator, numerator
    logic signed [XW-1:0] c1_reg, c2_reg, c3_reg, c4_reg, den_reg, num_reg;
    logic signed [DFW-1:0] s3_dx_reg, s3_dy_reg;
    logic [OUT_COORD_W-1:0] s3_sx_reg, s3_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg    <= XW'(p1a_reg) - XW'(p1b_reg);
            c2_reg    <= XW'(p2a_reg) - XW'(p2b_reg);
            c3_reg    <= XW'(p3a_reg) - XW'(p3b_reg);
            c4_reg    <= XW'(p4a_reg) - XW'(p4b_reg);
            den_reg   <= XW'(pda_reg) - XW'(pdb_reg);
            num_reg   <= XW'(pna_reg) - XW'(pnb_reg);
            s3_dx_reg <= s2_dx_reg;
            s3_dy_reg <= s2_dy_reg;
            s3_sx_reg <= s2_sx_reg;
            s3_sy_reg <= s2_sy_reg;
        end
    end

    // Stage 4: side tests, signs and magnitudes
    logic bad12, bad34;
    assign bad12 = (c1_reg != '0) && (c2_reg != '0) && (c1_reg[XW-1] == c2_reg[XW-1]);
    assign bad34 = (c3_reg != '0) && (c4_reg != '0) && (c3_reg[XW-1] == c4_reg[XW-1]);

    sip_ctl_t s4_ctl_next, s4_ctl_reg;
    always_comb
    begin
        s4_ctl_next.hit      = !bad12 && !bad34;
        s4_ctl_next.den_zero = (den_reg == '0);
        s4_ctl_next.neg_x    = num_reg[XW-1] ^ s3_dx_reg[DFW-1] ^ den_reg[XW-1];
        s4_ctl_next.neg_y    = num_reg[XW-1] ^ s3_dy_reg[DFW-1] ^ den_reg[XW-1];
    end

    logic [MW-1:0]  mnum_reg, mden_reg;
    logic [DFW-1:0] mdx_reg, mdy_reg;
    logic [OUT_COORD_W-1:0] s4_sx_reg, s4_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_ctl_reg <= s4_ctl_next;
            mnum_reg   <= MW'(num_reg[XW-1] ? -num_reg : num_reg);
            mden_reg   <= MW'(den_reg[XW-1] ? -den_reg : den_reg);
            mdx_reg    <= s3_dx_reg[DFW-1] ? -s3_dx_reg : s3_dx_reg;
            mdy_reg    <= s3_dy_reg[DFW-1] ? -s3_dy_reg : s3_dy_reg;
            s4_sx_reg  <= s3_sx_reg;
            s4_sy_reg  <= s3_sy_reg;
        end
    end

    // Stage 5: numerator times direction, split in two halves
    logic [H+DFW-1:0]  plx_reg, ply_reg;
    logic [HW+DFW-1:0] phx_reg, phy_reg;
    sip_ctl_t s5_ctl_reg;
    logic [MW-1:0] s5_den_reg;
    logic [OUT_COORD_W-1:0] s5_sx_reg, s5_sy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plx_reg    <= (H+DFW)'(mnum_reg[H-1:0]) * (H+DFW)'(mdx_reg);
            ply_reg    <= (H+DFW)'(mnum_reg[H-1:0]) * (H+DFW)'(mdy_reg);
            phx_reg    <= (HW+DFW)'(mnum_reg[MW-1:H]) * (HW+DFW)'(mdx_reg);
            phy_reg    <= (HW+DFW)'(mnum_reg[MW-1:H]) * (HW+DFW)'(mdy_reg);
            s5_ctl_reg <= s4_ctl_reg;
            s5_den_reg <= mden_reg;
            s5_sx_reg  <= s4_sx_reg;
            s5_sy_reg  <= s4_sy_reg;
        end
    end

    // Stage 6: combine halves and scale by the fraction
    logic [NPW-1:0] sum_x, sum_y;
    assign sum_x = (NPW'(phx_reg) << H) + NPW'(plx_reg);
    assign sum_y = (NPW'(phy_reg) << H) + NPW'(ply_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dvd_x   <= NW'(sum_x) << FRAC_BITS;
            out_dvd_y   <= NW'(sum_y) << FRAC_BITS;
            out_ctl     <= s5_ctl_reg;
            out_den     <= s5_den_reg;
            out_start_x <= s5_sx_reg;
            out_start_y <= s5_sy_reg;
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    assign out_valid = v_reg[5];

endmodule

`default_nettype wire

// ----- hw/rtl/sip_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per stage, two lanes sharing the divisor.
module sip_div
    import sip_pkg::*;
#(
    parameter int DW = 2 * (COORD_BITS_DEF + 1) + 1,
    parameter int NW = DW + COORD_BITS_DEF + 1 + FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire sip_ctl_t               in_ctl,
    input  wire logic [DW-1:0]          in_den,
    input  wire logic [NW-1:0]          in_dvd_x,
    input  wire logic [NW-1:0]          in_dvd_y,
    input  wire logic [OUT_COORD_W-1:0] in_start_x,
    input  wire logic [OUT_COORD_W-1:0] in_start_y,
    output logic                        out_valid,
    output sip_ctl_t                    out_ctl,
    output logic [OUT_COORD_W-1:0]      out_q_x,
    output logic [OUT_COORD_W-1:0]      out_q_y,
    output logic [OUT_COORD_W-1:0]      out_start_x,
    output logic [OUT_COORD_W-1:0]      out_start_y
);

    localparam int QW = OUT_COORD_W;

    logic                   v_reg   [NW];
    sip_ctl_t               ctl_reg [NW];
    logic [DW-1:0]          den_reg [NW];
    logic [DW-1:0]          rx_reg  [NW];
    logic [DW-1:0]          ry_reg  [NW];
    logic [NW-1:0]          dx_reg  [NW];
    logic [NW-1:0]          dy_reg  [NW];
    logic [QW-1:0]          qx_reg  [NW];
    logic [QW-1:0]          qy_reg  [NW];
    logic [OUT_COORD_W-1:0] sx_reg  [NW];
    logic [OUT_COORD_W-1:0] sy_reg  [NW];

    for (genvar i = 0; i < NW; i++)
    begin : g_stage
        logic                   pv;
        sip_ctl_t               pctl;
        logic [DW-1:0]          pden, prx, pry;
        logic [NW-1:0]          pdx, pdy;
        logic [QW-1:0]          pqx, pqy;
        logic [OUT_COORD_W-1:0] psx, psy;
        logic [DW:0]            tx, ty;
        logic                   gx, gy;

        if (i == 0)
        begin : g_first
            assign pv   = in_valid;
            assign pctl = in_ctl;
            assign pden = in_den;
            assign prx  = '0;
            assign pry  = '0;
            assign pdx  = in_dvd_x;
            assign pdy  = in_dvd_y;
            assign pqx  = '0;
            assign pqy  = '0;
            assign psx  = in_start_x;
            assign psy  = in_start_y;
        end
        else
        begin : g_next
            assign pv   = v_reg[i-1];
            assign pctl = ctl_reg[i-1];
            assign pden = den_reg[i-1];
            assign prx  = rx_reg[i-1];
            assign pry  = ry_reg[i-1];
            assign pdx  = dx_reg[i-1];
            assign pdy  = dy_reg[i-1];
            assign pqx  = qx_reg[i-1];
            assign pqy  = qy_reg[i-1];
            assign psx  = sx_reg[i-1];
            assign psy  = sy_reg[i-1];
        end

        // Shift in the next dividend bit and try the subtract
        assign tx = {prx, pdx[NW-1]};
        assign ty = {pry, pdy[NW-1]};
        assign gx = tx >= {1'b0, pden};
        assign gy = ty >= {1'b0, pden};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctl_reg[i] <= pctl;
                den_reg[i] <= pden;
                rx_reg[i]  <= gx ? DW'(tx - {1'b0, pden}) : DW'(tx);
                ry_reg[i]  <= gy ? DW'(ty - {1'b0, pden}) : DW'(ty);
                dx_reg[i]  <= pdx << 1;
                dy_reg[i]  <= pdy << 1;
                qx_reg[i]  <= {pqx[QW-2:0], gx};
                qy_reg[i]  <= {pqy[QW-2:0], gy};
                sx_reg[i]  <= psx;
                sy_reg[i]  <= psy;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= pv;
            end
        end
    end

    assign out_valid   = v_reg[NW-1];
    assign out_ctl     = ctl_reg[NW-1];
    assign out_q_x     = qx_reg[NW-1];
    assign out_q_y     = qy_reg[NW-1];
    assign out_start_x = sx_reg[NW-1];
    assign out_start_y = sy_reg[NW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/segment_intersection_point.sv -----
// Channel | Dir | Signals                      | Carries
// s       | in  | s_tvalid s_tready s_tdata    | two segments p1-p2, p3-p4
// m       | out | m_tvalid m_tready m_tdata    | crossing point x, y
//         |     | m_tuser                      | hit, degenerate flags
//
// One segment pair enters per cycle while the pipeline is not held. Pairs pass
// the front end, the divider and the output register in turn; NW = 3*COORD_BITS
// + 4 + FRAC_BITS is the dividend width and the divider spends one stage per dividend bit.
// The whole pipeline advances together; it holds while a result waits
// at the output and m_tready is low. Reset clears only the valid bits.
`default_nettype none

module segment_intersection_point
    import sip_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // cross_x, cross_y
    output logic [OUT_DATA_W-1:0]       m_tdata,
    // hit, degenerate, zero padding
    output logic [OUT_USER_W-1:0]       m_tuser
);

    localparam int MW = 2 * (COORD_BITS + 1) + 1;
    localparam int NW = MW + COORD_BITS + 1 + FRAC_BITS;

    logic en;
    logic m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    logic                   f_valid;
    sip_ctl_t               f_ctl;
    logic [MW-1:0]          f_den;
    logic [NW-1:0]          f_dvd_x, f_dvd_y;
    logic [OUT_COORD_W-1:0] f_sx, f_sy;

    sip_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .MW         (MW),
        .NW         (NW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_data     (s_tdata),
        .out_valid   (f_valid),
        .out_ctl     (f_ctl),
        .out_den     (f_den),
        .out_dvd_x   (f_dvd_x),
        .out_dvd_y   (f_dvd_y),
        .out_start_x (f_sx),
        .out_start_y (f_sy)
    );

    logic                   d_valid;
    sip_ctl_t               d_ctl;
    logic [OUT_COORD_W-1:0] d_qx, d_qy, d_sx, d_sy;

    sip_div #(
        .DW (MW),
        .NW (NW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (f_valid),
        .in_ctl      (f_ctl),
        .in_den      (f_den),
        .in_dvd_x    (f_dvd_x),
        .in_dvd_y    (f_dvd_y),
        .in_start_x  (f_sx),
        .in_start_y  (f_sy),
        .out_valid   (d_valid),
        .out_ctl     (d_ctl),
        .out_q_x     (d_qx),
        .out_q_y     (d_qy),
        .out_start_x (d_sx),
        .out_start_y (d_sy)
    );

    // Output stage: apply the sign and mask non-hits / zero denominators
    logic                   ok;
    logic [OUT_COORD_W-1:0] cx_next, cy_next;
    logic [OUT_COORD_W-1:0] cx_reg, cy_reg;
    logic                   hit_reg, degen_reg;

    assign ok      = d_ctl.hit && !d_ctl.den_zero;
    assign cx_next = ok ? (d_ctl.neg_x ? d_sx + d_qx : d_sx - d_qx) : '0;
    assign cy_next = ok ? (d_ctl.neg_y ? d_sy + d_qy : d_sy - d_qy) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            hit_reg   <= d_ctl.hit;
            degen_reg <= d_ctl.hit && d_ctl.den_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid_reg <= d_valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {cy_reg, cx_reg};
    assign m_tuser  = {{(OUT_USER_W-2){1'b0}}, degen_reg, hit_reg};

endmodule

`default_nettype wire

// ----- hw/rtl/sip_checker.sv -----
`default_nettype none

module sip_checker
    import sip_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [IN_DATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [OUT_USER_W-1:0] m_tuser
);

    // Degenerate only ever flags a hit
    a_degen_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("degenerate without hit");

    // A miss carries a zero point
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("miss with nonzero point");

    // A zero denominator carries a zero point
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("degenerate with nonzero point");

    // Input is refused only while a result is held back
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // A held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

endmodule

bind segment_intersection_point sip_checker u_sip_checker (.*);

`default_nettype wire

// ----- tb/tb_segment_intersection_point.sv -----
`timescale 1ns / 1ps

module tb_segment_intersection_point;
    import sip_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int LATENCY = 7 + 3 * COORD_BITS_DEF + 4 + FRAC_BITS_DEF;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] qy;
        logic signed [15:0] qx;
        logic signed [15:0] py;
        logic signed [15:0] px;
        logic signed [15:0] by;
        logic signed [15:0] bx;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
    } seg_pair_t;

    typedef struct packed {
        logic               hit;
        logic               degenerate;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } crossing_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    seg_pair_t pending_pairs[$];
    crossing_t expected_points[$];
    int        errors;
    int        hits_seen;
    int        degen_seen;
    int        results_seen;
    longint    cycle_count;
    bit        stim_done;
    int        send_wait;
    int        recv_wait;
    int        hold_cycles;

    segment_intersection_point uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int sign_of(longint v);
        return (v > 0) - (v < 0);
    endfunction

    // One coordinate: base*2^F - trunc(num*dir*2^F/den), low 32 bits
    function automatic logic [31:0] crossing_coord(longint base, longint num,
                                                   longint dir, longint den);
        logic signed [127:0] prod;
        logic signed [127:0] quot;
        logic signed [127:0] start;
        prod  = 128'(num) * 128'(dir);
        prod  = prod <<< FRAC;
        quot  = prod / 128'(den);
        start = 128'(base) <<< FRAC;
        return 32'(start - quot);
    endfunction

    function automatic crossing_t predict_crossing(seg_pair_t s);
        crossing_t r;
        longint d12x, d12y, d13x, d13y, d14x, d14y, d23x, d23y, d34x, d34y;
        longint c1, c2, c3, c4, den, num;
        d12x = s.ax - s.bx; d12y = s.ay - s.by;
        d13x = s.ax - s.px; d13y = s.ay - s.py;
        d14x = s.ax - s.qx; d14y = s.ay - s.qy;
        d23x = s.bx - s.px; d23y = s.by - s.py;
        d34x = s.px - s.qx; d34y = s.py - s.qy;
        c1 = d13x * d12y - d13y * d12x;
        c2 = d14x * d12y - d14y * d12x;
        c3 = d13y * d34x - d13x * d34y;
        c4 = d23y * d34x - d23x * d34y;
        r = '0;
        r.hit = (sign_of(c1) * sign_of(c2) <= 0) && (sign_of(c3) * sign_of(c4) <= 0);
        if (r.hit)
        begin
            den = d12x * d34y - d34x * d12y;
            num = d34y * d13x - d34x * d13y;
            if (den == 0)
                r.degenerate = 1'b1;
            else
            begin
                r.cx = crossing_coord(s.ax, num, d12x, den);
                r.cy = crossing_coord(s.ay, num, d12y, den);
            end
        end
        return r;
    endfunction

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'(int'($urandom_range(0, 65535)));
            1: return 16'(int'($urandom_range(0, 64)) - 32);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'(int'($urandom_range(0, 2000)) - 1000);
        endcase
    endfunction

    function automatic seg_pair_t make_pair(logic signed [15:0] ax, logic signed [15:0] ay,
                                            logic signed [15:0] bx, logic signed [15:0] by,
                                            logic signed [15:0] px, logic signed [15:0] py,
                                            logic signed [15:0] qx, logic signed [15:0] qy);
        seg_pair_t s;
        s.ax = ax; s.ay = ay; s.bx = bx; s.by = by;
        s.px = px; s.py = py; s.qx = qx; s.qy = qy;
        return s;
    endfunction

    // Stimulus: directed cases, then random pairs biased toward crossings
    initial
    begin
        seg_pair_t s;
        int mode;
        pending_pairs.push_back(make_pair(0, 0, 10, 10, 0, 10, 10, 0));       // plain X
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 0, 5, 10, 5));         // parallel miss
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 0, 20, 0));         // collinear overlap
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 20, 0, 30, 0));        // collinear disjoint
        pending_pairs.push_back(make_pair(3, 3, 3, 3, 0, 0, 6, 6));           // zero length
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 10, 0, 10, 10));       // touching end
        pending_pairs.push_back(make_pair(0, 0, 10, 0, 5, 1, 5, 10));         // near miss
        pending_pairs.push_back(make_pair(0, 0, 3, 7, 0, 5, 2, -4));          // inexact quotient
        pending_pairs.push_back(make_pair(-1, -1, 2, 2, -1, 2, 2, -1));
        pending_pairs.push_back(make_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                                          16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000));
        pending_pairs.push_back(make_pair(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                                          16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff));
        pending_pairs.push_back(make_pair(16'sh8000, 0, 16'sh7fff, 1,
                                          0, 16'sh8000, 1, 16'sh7fff));
        pending_pairs.push_back(make_pair(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        pending_pairs.push_back(make_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                          16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
        pending_pairs.push_back(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        repeat (1030)
        begin
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 9) < 6)
            begin
                // crossing by construction: second segment through the first's midpoint
                s.ax = rand_coord(mode); s.ay = rand_coord(mode);
                s.bx = rand_coord(mode); s.by = rand_coord(mode);
                s.px = rand_coord(mode); s.py = rand_coord(mode);
                s.qx = 16'((32'(s.ax) + 32'(s.bx)) - 32'(s.px));
                s.qy = 16'((32'(s.ay) + 32'(s.by)) - 32'(s.py));
                if ($urandom_range(0, 7) == 0)
                begin
                    s.px = s.ax; s.py = s.ay; s.qx = s.bx; s.qy = s.by;
                end
            end
            else
                s = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode),
                              rand_coord(mode), rand_coord(mode), rand_coord(mode),
                              rand_coord(mode), rand_coord(mode));
            pending_pairs.push_back(s);
        end
        stim_done = 1'b1;
    end

    // Reset and cycle counter
    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    // Driver: one request at a time with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_points.push_back(predict_crossing(seg_pair_t'(s_tdata)));
                void'(pending_pairs.pop_front());
                send_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
                if (send_wait == 0 && pending_pairs.size() > 0 && $urandom_range(0, 1))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs[0];
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid)
            begin
                if (send_wait > 0)
                    send_wait <= send_wait - 1;
                else if (pending_pairs.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_pairs[0];
                end
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                m_tready    <= 1'b0;
            end
            else if (cycle_count == 3000)
            begin
                hold_cycles <= 400;
                m_tready    <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait <= recv_wait - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_wait <= $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            end
        end
    end

    // Monitor: compare every accepted result with the oldest prediction
    always @(posedge clk)
    begin
        crossing_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result tdata=%h tuser=%h", $time, m_tdata, m_tuser);
                errors = errors + 1;
            end
            else
            begin
                want = expected_points.pop_front();
                if (want.hit) hits_seen <= hits_seen + 1;
                if (want.degenerate) degen_seen <= degen_seen + 1;
                if (m_tuser[0] !== want.hit || m_tuser[1] !== want.degenerate)
                begin
                    $display("%0t: flags expected hit=%b degenerate=%b, got hit=%b degenerate=%b",
                             $time, want.hit, want.degenerate, m_tuser[0], m_tuser[1]);
                    errors = errors + 1;
                end
                if (m_tdata[31:0] !== want.cx)
                begin
                    $display("%0t: cross_x expected %h, got %h", $time, want.cx, m_tdata[31:0]);
                    errors = errors + 1;
                end
                if (m_tdata[63:32] !== want.cy)
                begin
                    $display("%0t: cross_y expected %h, got %h", $time, want.cy, m_tdata[63:32]);
                    errors = errors + 1;
                end
            end
        end
    end

    // Drain and report
    initial
    begin
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        errors       = 0;
        hits_seen    = 0;
        degen_seen   = 0;
        results_seen = 0;
        cycle_count  = 0;
        send_wait    = 0;
        recv_wait    = 0;
        hold_cycles  = 0;
        wait (stim_done);
        while (pending_pairs.size() > 0 || s_tvalid || expected_points.size() > 0)
            @(posedge clk);
        repeat (2 * LATENCY) @(posedge clk);
        $display("checked %0d segment pairs: %0d hits, %0d degenerate",
                 results_seen, hits_seen, degen_seen);
        $display("covered coordinate extremes, collinear and zero-length cases, long output stall");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
